@@ sv/japid_pkg.sv @@
// Shared types, constants and helpers of the joint angle PID effort unit.
package japid_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int GAIN_BITS      = 16;
  localparam int LIMIT_BITS     = 32;
  localparam int DRIVE_BITS     = 15;
  localparam int REG_DATA_BITS  = 32;
  localparam int REG_INDEX_BITS = 3;

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_INTEG_UPPER  = 3'd3,
    REG_INTEG_LOWER  = 3'd4,
    REG_TARGET_UPPER = 3'd5,
    REG_TARGET_LOWER = 3'd6,
    REG_DRIVE_LIMIT  = 3'd7
  } cfg_reg_t;

  // Limits used by the error and integrator stage.
  typedef struct packed {
    logic signed [LIMIT_BITS-1:0] integ_upper;
    logic signed [LIMIT_BITS-1:0] integ_lower;
    logic signed [ANGLE_BITS-1:0] target_upper;
    logic signed [ANGLE_BITS-1:0] target_lower;
  } track_cfg_t;

  // The integrator must hold both the saturated sum and any 32-bit limit value.
  function automatic int integ_width(input int sum_bits);
    return (sum_bits > LIMIT_BITS) ? sum_bits : LIMIT_BITS;
  endfunction

endpackage

@@ sv/japid_ifs.sv @@
// Command and result channel interfaces of the joint angle PID effort unit.
interface japid_cmd_if import japid_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [ANGLE_BITS-1:0] target_angle;
  logic signed [ANGLE_BITS-1:0] measured_angle;
  logic                         sample_ok;

  modport source (output valid, op, target_angle, measured_angle, sample_ok, input ready);
  modport sink (input valid, op, target_angle, measured_angle, sample_ok, output ready);
endinterface

interface japid_res_if import japid_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] effort;
  logic signed [ANGLE_BITS-1:0] angle_error;
  logic                         saturated;

  modport source (output valid, effort, angle_error, saturated, input ready);
  modport sink (input valid, effort, angle_error, saturated, output ready);
endinterface

@@ sv/japid_track.sv @@
// Target store, wrapped angle error, clamped integrator and error difference.
module japid_track import japid_pkg::*; #(
  parameter int SUM_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  track_cfg_t                                cfg,
  input  logic                                      load,
  input  logic                                      op,
  input  logic signed [ANGLE_BITS-1:0]              target_angle,
  input  logic signed [ANGLE_BITS-1:0]              measured_angle,
  input  logic                                      sample_ok,
  output logic signed [ANGLE_BITS-1:0]              angle_error,
  output logic signed [integ_width(SUM_BITS)-1:0]   integ_sum,
  output logic signed [ANGLE_BITS:0]                error_diff
);

  localparam int IW = integ_width(SUM_BITS);
  localparam int RW = IW + 1;
  localparam logic signed [RW-1:0] SUM_MAX =
    {{(RW-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] SUM_MIN = ~SUM_MAX;

  logic signed [ANGLE_BITS-1:0] target;
  logic signed [IW-1:0]         error_sum;
  logic signed [ANGLE_BITS-1:0] previous_error;

  logic signed [ANGLE_BITS-1:0] target_next;
  logic signed [ANGLE_BITS-1:0] error_next;
  logic signed [RW-1:0]         sum_raw;
  logic signed [RW-1:0]         sum_sat;
  logic signed [RW-1:0]         integ_lo;
  logic signed [RW-1:0]         integ_hi;
  logic signed [IW-1:0]         sum_next;
  logic signed [ANGLE_BITS:0]   diff_next;

  always_comb begin
    target_next = target_angle;
    if (target_next < cfg.target_lower) target_next = cfg.target_lower;
    if (target_next > cfg.target_upper) target_next = cfg.target_upper;

    // Modular subtraction gives the shortest error; half a turn reads negative.
    error_next = target - measured_angle;

    sum_raw = RW'(error_sum) + RW'(error_next);
    sum_sat = sum_raw;
    if (sum_raw > SUM_MAX) sum_sat = SUM_MAX;
    if (sum_raw < SUM_MIN) sum_sat = SUM_MIN;
    integ_lo = RW'(cfg.integ_lower);
    integ_hi = RW'(cfg.integ_upper);
    if (sum_sat < integ_lo) sum_sat = integ_lo;
    if (sum_sat > integ_hi) sum_sat = integ_hi;
    sum_next = sum_sat[IW-1:0];

    diff_next = (ANGLE_BITS+1)'(error_next) - (ANGLE_BITS+1)'(previous_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target         <= '0;
      error_sum      <= '0;
      previous_error <= '0;
    end else if (load) begin
      if (op == OP_SET) begin
        target <= target_next;
      end else if (sample_ok) begin
        error_sum      <= sum_next;
        previous_error <= error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      angle_error <= error_next;
      integ_sum   <= sum_next;
      error_diff  <= diff_next;
    end
  end

endmodule

@@ sv/joint_angle_pid_effort_unit.sv @@
// Top level of the joint angle PID effort unit: registers, pipeline and output stage.
//
//   Channel  Direction  Carries                                       Transaction when
//   cmd      in         op, target_angle, measured_angle, sample_ok   cmd.valid && cmd.ready
//   res      out        effort, angle_error, saturated                res.valid && res.ready
//   wr_*     in         wr_index, wr_data                             wr_en
//
// One command is taken per cycle while a stall on res does not hold cmd.ready low; a tick
// result passes the state update and product registers into the result register.
// Stages: input register, error and integrator update, three products, sum and saturation.
// The target, integrator and previous error update in the second stage, so the next
// command always sees the state left by the one before it.
// Reset clears the pipeline and sets the registers to their defaults; a stall on res
// holds every stage that cannot move.
module joint_angle_pid_effort_unit import japid_pkg::*; #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int SUM_BITS       = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [REG_INDEX_BITS-1:0] wr_index,
  input  logic [REG_DATA_BITS-1:0]  wr_data,
  japid_cmd_if.sink                 cmd,
  japid_res_if.source               res
);

  localparam int IW = integ_width(SUM_BITS);
  localparam int PW = GAIN_BITS + ANGLE_BITS;
  localparam int IPW = GAIN_BITS + IW;
  localparam int DPW = GAIN_BITS + ANGLE_BITS + 1;
  localparam int AW = IPW + 2;

  // Configuration registers
  logic signed [GAIN_BITS-1:0] prop_gain;
  logic signed [GAIN_BITS-1:0] integ_gain;
  logic signed [GAIN_BITS-1:0] deriv_gain;
  logic        [DRIVE_BITS-1:0] drive_limit;
  track_cfg_t                  track_cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain              <= '0;
      integ_gain             <= '0;
      deriv_gain             <= '0;
      track_cfg.integ_upper  <= '0;
      track_cfg.integ_lower  <= '0;
      track_cfg.target_upper <= {1'b0, {(ANGLE_BITS-1){1'b1}}};
      track_cfg.target_lower <= {1'b1, {(ANGLE_BITS-1){1'b0}}};
      drive_limit            <= '1;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_PROP_GAIN:    prop_gain <= wr_data[GAIN_BITS-1:0];
        REG_INTEG_GAIN:   integ_gain <= wr_data[GAIN_BITS-1:0];
        REG_DERIV_GAIN:   deriv_gain <= wr_data[GAIN_BITS-1:0];
        REG_INTEG_UPPER:  track_cfg.integ_upper <= wr_data[LIMIT_BITS-1:0];
        REG_INTEG_LOWER:  track_cfg.integ_lower <= wr_data[LIMIT_BITS-1:0];
        REG_TARGET_UPPER: track_cfg.target_upper <= wr_data[ANGLE_BITS-1:0];
        REG_TARGET_LOWER: track_cfg.target_lower <= wr_data[ANGLE_BITS-1:0];
        REG_DRIVE_LIMIT:  drive_limit <= wr_data[DRIVE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its content moves on.
  logic v1, v2, v3, ov;
  logic take_out, ld3, ld2, ld1;

  assign take_out  = !ov || res.ready;
  assign ld3       = !v3 || take_out;
  assign ld2       = !v2 || ld3;
  assign ld1       = !v1 || ld2;
  assign cmd.ready = ld1;

  // Stage 1: input register
  logic                         s1_op;
  logic signed [ANGLE_BITS-1:0] s1_target_angle;
  logic signed [ANGLE_BITS-1:0] s1_measured_angle;
  logic                         s1_sample_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && cmd.valid) begin
      s1_op             <= cmd.op;
      s1_target_angle   <= cmd.target_angle;
      s1_measured_angle <= cmd.measured_angle;
      s1_sample_ok      <= cmd.sample_ok;
    end
  end

  // Stage 2: state update; only valid ticks go further down the pipeline.
  logic                         s2_load;
  logic signed [ANGLE_BITS-1:0] s2_error;
  logic signed [IW-1:0]         s2_sum;
  logic signed [ANGLE_BITS:0]   s2_diff;

  assign s2_load = v1 && ld2;

  japid_track #(
    .SUM_BITS (SUM_BITS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .cfg            (track_cfg),
    .load           (s2_load),
    .op             (s1_op),
    .target_angle   (s1_target_angle),
    .measured_angle (s1_measured_angle),
    .sample_ok      (s1_sample_ok),
    .angle_error    (s2_error),
    .integ_sum      (s2_sum),
    .error_diff     (s2_diff)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1 && (s1_op == OP_TICK) && s1_sample_ok;
    end
  end

  // Stage 3: products
  logic signed [PW-1:0]         p_prop;
  logic signed [IPW-1:0]        p_integ;
  logic signed [DPW-1:0]        p_deriv;
  logic signed [ANGLE_BITS-1:0] s3_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && v2) begin
      p_prop   <= prop_gain * s2_error;
      p_integ  <= integ_gain * s2_sum;
      p_deriv  <= deriv_gain * s2_diff;
      s3_error <= s2_error;
    end
  end

  // Stage 4: sum, floor shift and symmetric saturation into the result register.
  logic signed [AW-1:0]         acc;
  logic signed [AW-1:0]         eff;
  logic signed [AW-1:0]         lim_pos;
  logic signed [AW-1:0]         lim_neg;
  logic signed [ANGLE_BITS-1:0] effort_next;
  logic                         sat_next;

  always_comb begin
    acc     = AW'(p_prop) + AW'(p_integ) + AW'(p_deriv);
    eff     = acc >>> GAIN_FRAC_BITS;
    lim_pos = signed'(AW'(drive_limit));
    lim_neg = -lim_pos;
    sat_next = 1'b0;
    effort_next = eff[ANGLE_BITS-1:0];
    if (eff > lim_pos) begin
      effort_next = lim_pos[ANGLE_BITS-1:0];
      sat_next    = 1'b1;
    end
    if (eff < lim_neg) begin
      effort_next = lim_neg[ANGLE_BITS-1:0];
      sat_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (take_out) begin
      ov <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out && v3) begin
      res.effort      <= effort_next;
      res.angle_error <= s3_error;
      res.saturated   <= sat_next;
    end
  end

  assign res.valid = ov;

endmodule
